>>> rtl/tpvc_pkg.sv
// Package for the theremin pitch and volume conditioner.
// Holds the word types, register indexes, reset values and fixed limits.
// No dependencies.
package tpvc_pkg;

	localparam int COUNTER_BITS_DEF = 16;

	localparam int unsigned PITCH_MAX = 16383;
	localparam int unsigned VOL_FLOOR = 5000;
	localparam int unsigned DAC_MAX   = 4095;
	localparam int unsigned PITCH_MID = 2048;
	localparam int unsigned VOL_OFFS  = 1024;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	typedef enum logic [2:0] {
		REG_PITCH_BASE  = 3'd0,
		REG_VOLUME_BASE = 3'd1,
		REG_OCTAVE      = 3'd2,
		REG_AUDIO_ON    = 3'd3,
		REG_SYMMETRIC   = 3'd4,
		REG_LINEAR_CV   = 3'd5
	} reg_idx_t;

	localparam logic [1:0] OCTAVE_RST    = 2'd2;
	localparam logic       AUDIO_ON_RST  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] reading;
		logic [9:0]  knob;
	} item_t;

	typedef struct packed {
		logic        kind_out;
		logic [13:0] sample_advance;
		logic [15:0] scaled_volume;
		logic [11:0] cv_value;
		logic        cv_new;
	} result_t;

	typedef struct packed {
		logic [15:0] pitch_base;
		logic [15:0] volume_base;
		logic [1:0]  octave_shift;
		logic        audio_on;
		logic        symmetric_field;
		logic        linear_cv_on;
	} cfg_t;

	typedef struct packed {
		logic [15:0] pitch_average;
		logic [15:0] volume_average;
		logic [13:0] last_cv_pitch;
	} state_t;

endpackage

>>> rtl/tpvc_map.sv
// Single-pass mapping of one counter word to its result and next channel state.
// Purely combinational; depends on tpvc_pkg.
module tpvc_map import tpvc_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  cfg_t    cfg,
	input  state_t  st,
	input  item_t   item,
	output result_t res,
	output state_t  nxt
);

	localparam int MASK_BITS = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
	localparam logic [15:0] READ_MASK = 16'((33'd1 << MASK_BITS) - 33'd1);

	logic [15:0]        reading_m;
	// pitch path
	logic signed [16:0] p_diff;
	logic signed [16:0] p_sum;
	logic [15:0]        p_avg_n;
	logic signed [19:0] p_raw;
	logic signed [19:0] p_abs;
	logic [13:0]        p_clamp;
	logic [13:0]        advance;
	logic [1:0]         cv_sh;
	logic [11:0]        cv_p;
	logic               p_changed;
	// volume path
	logic [15:0]        v_read;
	logic signed [16:0] v_diff;
	logic signed [16:0] v_sum;
	logic [15:0]        v_avg_n;
	logic signed [16:0] b_diff;
	logic signed [16:0] b_half;
	logic signed [19:0] v_raw;
	logic [11:0]        v_clamp;
	logic [7:0]         c;
	logic [8:0]         c2;
	logic [16:0]        prod;

	assign reading_m = item.reading & READ_MASK;

	// Quarter step toward the reading; arithmetic shift rounds toward minus infinity.
	assign p_diff  = $signed({1'b0, reading_m}) - $signed({1'b0, st.pitch_average});
	assign p_sum   = $signed({1'b0, st.pitch_average}) + (p_diff >>> 2);
	assign p_avg_n = p_sum[15:0];

	// Normal and symmetrical fields share the same distance, the latter takes its magnitude.
	assign p_raw = $signed({4'b0, cfg.pitch_base}) - $signed({4'b0, p_avg_n})
		+ 20'(PITCH_MID) - $signed({8'b0, item.knob, 2'b0});
	assign p_abs = (cfg.symmetric_field && p_raw < 0) ? -p_raw : p_raw;

	always_comb begin
		if (p_abs < 0) begin
			p_clamp = '0;
		end else if (p_abs > $signed(20'(PITCH_MAX))) begin
			p_clamp = 14'(PITCH_MAX);
		end else begin
			p_clamp = p_abs[13:0];
		end
	end

	assign advance   = p_clamp >> cfg.octave_shift;
	assign cv_sh     = (cfg.octave_shift == 2'd0) ? 2'd0 : cfg.octave_shift - 2'd1;
	assign cv_p      = p_clamp[13:2] >> cv_sh;
	assign p_changed = (p_clamp != st.last_cv_pitch);

	assign v_read  = (reading_m < 16'(VOL_FLOOR)) ? 16'(VOL_FLOOR) : reading_m;
	assign v_diff  = $signed({1'b0, v_read}) - $signed({1'b0, st.volume_average});
	assign v_sum   = $signed({1'b0, st.volume_average}) + (v_diff >>> 2);
	assign v_avg_n = v_sum[15:0];

	// Halve toward zero: bias negatives by one before the shift.
	assign b_diff = $signed({1'b0, cfg.volume_base}) - $signed({1'b0, v_avg_n});
	assign b_half = (b_diff + $signed({16'b0, b_diff[16]})) >>> 1;
	assign v_raw  = 20'(DAC_MAX - VOL_OFFS) - $signed({{3{b_half[16]}}, b_half})
		+ $signed({8'b0, item.knob, 2'b0});

	always_comb begin
		if (!cfg.audio_on || v_raw < 0) begin
			v_clamp = '0;
		end else if (v_raw > $signed(20'(DAC_MAX))) begin
			v_clamp = 12'(DAC_MAX);
		end else begin
			v_clamp = v_raw[11:0];
		end
	end

	assign c    = v_clamp[11:4];
	assign c2   = {1'b0, c} + 9'd2;
	assign prod = 17'(c) * 17'(c2);

	always_comb begin
		nxt = st;
		res.kind_out = item.kind;
		if (!item.kind) begin
			nxt.pitch_average  = p_avg_n;
			res.sample_advance = advance;
			res.scaled_volume  = '0;
			res.cv_new         = cfg.linear_cv_on && p_changed;
			res.cv_value       = res.cv_new ? cv_p : '0;
			if (res.cv_new) begin
				nxt.last_cv_pitch = p_clamp;
			end
		end else begin
			nxt.volume_average = v_avg_n;
			res.sample_advance = '0;
			res.scaled_volume  = prod[15:0];
			res.cv_new         = cfg.linear_cv_on;
			res.cv_value       = cfg.linear_cv_on ? v_clamp : '0;
		end
	end

endmodule

>>> rtl/theremin_pitch_volume_conditioner.sv
// The result of an accepted word is registered and shows in the cycle after it is taken.
// Throughput: one word per cycle while result_ready holds; the result register frees as it is taken.
// The critical path runs through the averaging adder, the clamp and the 8x9 squarer.
// Reset: averages and last pitch CV clear, registers return to their defaults,
// the result register empties; no clearing pass.
module theremin_pitch_volume_conditioner import tpvc_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_nxt;
	result_t res_nxt;
	result_t result_q;
	logic    result_valid_q;
	logic    accept;
	logic    wr_en;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pitch_base: '0, volume_base: '0, octave_shift: OCTAVE_RST,
				audio_on: AUDIO_ON_RST, symmetric_field: 1'b0, linear_cv_on: 1'b0};
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_PITCH_BASE:  cfg_q.pitch_base      <= pwdata[15:0];
				REG_VOLUME_BASE: cfg_q.volume_base     <= pwdata[15:0];
				REG_OCTAVE:      cfg_q.octave_shift    <= pwdata[1:0];
				REG_AUDIO_ON:    cfg_q.audio_on        <= pwdata[0];
				REG_SYMMETRIC:   cfg_q.symmetric_field <= pwdata[0];
				REG_LINEAR_CV:   cfg_q.linear_cv_on    <= pwdata[0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PITCH_BASE:  prdata = {16'b0, cfg_q.pitch_base};
			REG_VOLUME_BASE: prdata = {16'b0, cfg_q.volume_base};
			REG_OCTAVE:      prdata = {30'b0, cfg_q.octave_shift};
			REG_AUDIO_ON:    prdata = {31'b0, cfg_q.audio_on};
			REG_SYMMETRIC:   prdata = {31'b0, cfg_q.symmetric_field};
			REG_LINEAR_CV:   prdata = {31'b0, cfg_q.linear_cv_on};
			default:         prdata = '0;
		endcase
	end

	tpvc_map #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_map (
		.cfg  (cfg_q),
		.st   (st_q),
		.item (item),
		.res  (res_nxt),
		.nxt  (st_nxt)
	);

	// Take a new word whenever the result register is empty or being emptied.
	assign item_ready = !result_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q           <= st_nxt;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> rtl/tpvc_checker.sv
// Port-level checks for the theremin pitch and volume conditioner.
// Depends on tpvc_pkg; bound to the top level below.
module tpvc_checker import tpvc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// Hold a stalled result word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty result register");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted word produced no result");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.kind_out ? (result.sample_advance == '0)
			: (result.scaled_volume == '0)))
		else $error("result field set for the wrong channel");

endmodule

bind theremin_pitch_volume_conditioner tpvc_checker u_tpvc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
